[src/cbm_pkg.sv]
package cbm_pkg;

  // Request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_PRG   = 2'd2;
  localparam logic [1:0] REQ_CHR   = 2'd3;

  // Address ranges, decoded from address bits [15:13]
  localparam logic [2:0] RANGE_CMD    = 3'd4;  // 0x8000-0x9FFF
  localparam logic [2:0] RANGE_PARAM  = 3'd5;  // 0xA000-0xBFFF
  localparam logic [2:0] WIN_CHR      = 3'd0;  // PPU 0x0000-0x1FFF
  localparam logic [2:0] WIN_LOW      = 3'd3;  // 0x6000-0x7FFF
  localparam logic [2:0] WIN_PRG_BASE = 3'd4;  // first switchable 8K window
  localparam logic [2:0] WIN_FIXED    = 3'd7;  // 0xE000-0xFFFF

  // Commands latched by a write to the command range
  localparam logic [3:0] CMD_PRG_RAM  = 4'd8;
  localparam logic [3:0] CMD_PRG0     = 4'd9;
  localparam logic [3:0] CMD_PRG1     = 4'd10;
  localparam logic [3:0] CMD_PRG2     = 4'd11;
  localparam logic [3:0] CMD_MIRROR   = 4'd12;
  localparam logic [3:0] CMD_IRQ_CTRL = 4'd13;
  localparam logic [3:0] CMD_IRQ_LO   = 4'd14;
  localparam logic [3:0] CMD_IRQ_HI   = 4'd15;

  // Configuration register indexes
  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_ROM  = 1'b1;

  localparam logic [15:0] IRQ_RELOAD     = 16'hFFFF;
  localparam logic [7:0]  PRG_MASK_RESET = 8'hFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] cpu_address;
    logic [7:0]  data_value;
  } in_t;

  typedef struct packed {
    logic [20:0] mapped_address;
    logic        target_is_ram;
    logic        access_enabled;
    logic [1:0]  mirroring_mode;
    logic        irq_line;
  } out_t;

  typedef struct packed {
    logic [20:0] mapped_address;
    logic        target_is_ram;
    logic        access_enabled;
  } lookup_t;

  typedef struct packed {
    logic [7:0] prg_bank_mask;
    logic       chr_is_rom;
  } cfg_t;

  typedef struct packed {
    logic [7:0][7:0] chr_bank;
    logic [2:0][7:0] prg_bank;
    logic [5:0]      low_prg_bank;
    logic            low_window_ram;
    logic            prg_ram_enable;
  } map_state_t;

  typedef struct packed {
    logic [1:0] mirror_nxt;
    logic       irq_nxt;
    logic       irq_cur;
  } status_t;

endpackage

[src/cartridge_bank_mapper_with_irq_counter.sv]
// Flow: an accepted beat waits in the input register, then moves to the result
//   register once that slot frees up. Throughput: one beat per cycle while
//   out_stall is low; input and result registers are the only stages, and all
//   non-config state updates in the cycle the beat leaves the input register.
// Reset: rst_n is synchronous, active low; it empties both stages and returns
//   the bank, command, IRQ and configuration registers to their reset values.
module cartridge_bank_mapper_with_irq_counter
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic       valid1_r;
  in_t        item_r;
  logic       out_valid_r;
  out_t       out_r;
  logic       advance;
  cfg_t       cfg;
  map_state_t map_st;
  status_t    status;
  lookup_t    lk;
  out_t       result;

  // move the held beat into the result register when that slot frees up
  assign advance  = valid1_r && (!out_valid_r || !out_stall);
  assign in_stall = valid1_r && !advance;

  cbm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (advance),
    .item      (item_r),
    .cfg       (cfg),
    .map_st    (map_st),
    .status    (status)
  );

  cbm_lookup u_lookup (
    .item   (item_r),
    .cfg    (cfg),
    .map_st (map_st),
    .res    (lk)
  );

  always_comb begin
    result.mapped_address = lk.mapped_address;
    result.target_is_ram  = lk.target_is_ram;
    result.access_enabled = lk.access_enabled;
    result.mirroring_mode = status.mirror_nxt;
    result.irq_line       = status.irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) valid1_r <= in_valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
    if (advance) out_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // writes and ticks never produce a lookup result
  a_no_lookup_on_ctrl : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (item_r.req_type == REQ_WRITE || item_r.req_type == REQ_TICK))
    |=> (out_r.mapped_address == '0 && !out_r.access_enabled && !out_r.target_is_ram))
    else $error("control beat produced a lookup result");

  // only a counter tick can raise the irq
  a_irq_rise_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.req_type != REQ_TICK) |-> !(status.irq_nxt && !status.irq_cur))
    else $error("irq raised by a non-tick beat");

  // a held beat stays put until it moves on
  a_hold_input_stage : assert property (@(posedge clk) disable iff (!rst_n)
    (valid1_r && !advance) |=> (valid1_r && $stable(item_r)))
    else $error("input stage lost or changed a held beat");

endmodule

[src/cbm_regs.sv]
module cbm_regs
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       step_en,
  input  in_t        item,
  output cfg_t       cfg,
  output map_state_t map_st,
  output status_t    status
);

  logic [7:0]      prg_mask_r;
  logic            chr_rom_r;
  logic [3:0]      cmd_r, cmd_nxt;
  logic [7:0][7:0] chr_bank_r, chr_bank_nxt;
  logic [2:0][7:0] prg_bank_r, prg_bank_nxt;
  logic [5:0]      low_bank_r, low_bank_nxt;
  logic            low_ram_r, low_ram_nxt;
  logic            ram_en_r, ram_en_nxt;
  logic [1:0]      mirror_r, mirror_nxt;
  logic [15:0]     count_r, count_nxt;
  logic            count_en_r, count_en_nxt;
  logic            trig_en_r, trig_en_nxt;
  logic            pending_r, pending_nxt;
  logic [15:0]     count_dec;
  logic [1:0]      prg_sel;
  logic [2:0]      range;

  assign count_dec = count_r - 16'd1;
  assign prg_sel   = 2'(cmd_r - CMD_PRG0);
  assign range     = item.cpu_address[15:13];

  always_comb begin
    cmd_nxt      = cmd_r;
    chr_bank_nxt = chr_bank_r;
    prg_bank_nxt = prg_bank_r;
    low_bank_nxt = low_bank_r;
    low_ram_nxt  = low_ram_r;
    ram_en_nxt   = ram_en_r;
    mirror_nxt   = mirror_r;
    count_nxt    = count_r;
    count_en_nxt = count_en_r;
    trig_en_nxt  = trig_en_r;
    pending_nxt  = pending_r;
    if (step_en) begin
      case (item.req_type)
        REQ_WRITE: begin
          if (range == RANGE_CMD) begin
            cmd_nxt = item.data_value[3:0];
          end else if (range == RANGE_PARAM) begin
            if (!cmd_r[3]) begin
              chr_bank_nxt[cmd_r[2:0]] = item.data_value;
            end else begin
              case (cmd_r)
                CMD_PRG_RAM: begin
                  ram_en_nxt   = item.data_value[7];
                  low_ram_nxt  = item.data_value[6];
                  low_bank_nxt = item.data_value[5:0];
                end
                CMD_PRG0, CMD_PRG1, CMD_PRG2: prg_bank_nxt[prg_sel] = item.data_value;
                CMD_MIRROR: mirror_nxt = item.data_value[1:0];
                CMD_IRQ_CTRL: begin
                  count_en_nxt = item.data_value[7];
                  trig_en_nxt  = item.data_value[0];
                  // dropping the trigger acknowledges a pending irq
                  if (!item.data_value[0]) pending_nxt = 1'b0;
                end
                CMD_IRQ_LO: count_nxt = {count_r[15:8], item.data_value};
                CMD_IRQ_HI: count_nxt = {item.data_value, count_r[7:0]};
                default: ;
              endcase
            end
          end
        end
        REQ_TICK: begin
          if (count_en_r) begin
            if (count_dec == 16'd0) begin
              count_nxt = IRQ_RELOAD;
              if (trig_en_r) pending_nxt = 1'b1;
            end else begin
              count_nxt = count_dec;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r <= PRG_MASK_RESET;
      chr_rom_r  <= 1'b1;
      cmd_r      <= '0;
      chr_bank_r <= '0;
      prg_bank_r <= '0;
      low_bank_r <= '0;
      low_ram_r  <= 1'b0;
      ram_en_r   <= 1'b0;
      mirror_r   <= '0;
      count_r    <= IRQ_RELOAD;
      count_en_r <= 1'b0;
      trig_en_r  <= 1'b0;
      pending_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_PRG_MASK) prg_mask_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_CHR_ROM)  chr_rom_r  <= cfg_data[0];
      cmd_r      <= cmd_nxt;
      chr_bank_r <= chr_bank_nxt;
      prg_bank_r <= prg_bank_nxt;
      low_bank_r <= low_bank_nxt;
      low_ram_r  <= low_ram_nxt;
      ram_en_r   <= ram_en_nxt;
      mirror_r   <= mirror_nxt;
      count_r    <= count_nxt;
      count_en_r <= count_en_nxt;
      trig_en_r  <= trig_en_nxt;
      pending_r  <= pending_nxt;
    end
  end

  assign cfg.prg_bank_mask = prg_mask_r;
  assign cfg.chr_is_rom    = chr_rom_r;

  assign map_st.chr_bank       = chr_bank_r;
  assign map_st.prg_bank       = prg_bank_r;
  assign map_st.low_prg_bank   = low_bank_r;
  assign map_st.low_window_ram = low_ram_r;
  assign map_st.prg_ram_enable = ram_en_r;

  assign status.mirror_nxt = mirror_nxt;
  assign status.irq_nxt    = pending_nxt;
  assign status.irq_cur    = pending_r;

endmodule

[src/cbm_lookup.sv]
module cbm_lookup
  import cbm_pkg::*;
(
  input  in_t        item,
  input  cfg_t       cfg,
  input  map_state_t map_st,
  output lookup_t    res
);

  logic [2:0] region;
  logic [1:0] prg_sel;
  logic [7:0] bank;

  assign region  = item.cpu_address[15:13];
  assign prg_sel = 2'(region - WIN_PRG_BASE);

  always_comb begin
    res  = '0;
    bank = '0;
    case (item.req_type)
      REQ_PRG: begin
        if (region >= WIN_LOW) begin
          res.access_enabled = 1'b1;
          if (region == WIN_LOW) begin
            if (map_st.low_window_ram) begin
              // RAM bank goes out unmasked, gated by the RAM enable
              bank               = {2'b00, map_st.low_prg_bank};
              res.target_is_ram  = 1'b1;
              res.access_enabled = map_st.prg_ram_enable;
            end else begin
              bank = {2'b00, map_st.low_prg_bank} & cfg.prg_bank_mask;
            end
          end else if (region == WIN_FIXED) begin
            bank = cfg.prg_bank_mask;
          end else begin
            bank = map_st.prg_bank[prg_sel] & cfg.prg_bank_mask;
          end
          res.mapped_address = {bank, item.cpu_address[12:0]};
        end
      end
      REQ_CHR: begin
        if (region == WIN_CHR) begin
          bank               = map_st.chr_bank[item.cpu_address[12:10]];
          res.mapped_address = {3'b000, bank, item.cpu_address[9:0]};
          res.target_is_ram  = !cfg.chr_is_rom;
          res.access_enabled = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[dv/mapper_scoreboard_pkg.sv]
package mapper_scoreboard_pkg;
  import cbm_pkg::*;

  class mapper_scoreboard;
    logic [7:0]  prg_mask;
    logic        chr_rom;
    logic [3:0]  cmd_sel;
    logic [7:0]  chr_bank [8];
    logic [5:0]  low_bank;
    logic        low_is_ram;
    logic        ram_enable;
    logic [7:0]  prg_bank [3];
    logic [1:0]  mirror;
    logic [15:0] irq_count;
    logic        count_en;
    logic        trigger_en;
    logic        irq_pending;
    out_t        expected_q [$];
    int unsigned errors;

    function new();
      prg_mask    = PRG_MASK_RESET;
      chr_rom     = 1'b1;
      cmd_sel     = '0;
      foreach (chr_bank[i]) chr_bank[i] = '0;
      foreach (prg_bank[i]) prg_bank[i] = '0;
      low_bank    = '0;
      low_is_ram  = 1'b0;
      ram_enable  = 1'b0;
      mirror      = '0;
      irq_count   = IRQ_RELOAD;
      count_en    = 1'b0;
      trigger_en  = 1'b0;
      irq_pending = 1'b0;
      errors      = 0;
    endfunction

    function void set_config(logic [7:0] mask, logic rom);
      prg_mask = mask;
      chr_rom  = rom;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the mapper state by one accepted beat and queue its result.
    function void note_request(in_t req);
      out_t       res;
      logic [7:0] bank;
      logic [2:0] win;
      logic [7:0] v;
      res  = '0;
      bank = '0;
      win  = req.cpu_address[15:13];
      v    = req.data_value;
      case (req.req_type)
        REQ_WRITE: begin
          if (win == RANGE_CMD) begin
            cmd_sel = v[3:0];
          end else if (win == RANGE_PARAM) begin
            if (cmd_sel < CMD_PRG_RAM) begin
              chr_bank[cmd_sel[2:0]] = v;
            end else begin
              case (cmd_sel)
                CMD_PRG_RAM: begin
                  ram_enable = v[7];
                  low_is_ram = v[6];
                  low_bank   = v[5:0];
                end
                CMD_PRG0, CMD_PRG1, CMD_PRG2: prg_bank[cmd_sel - CMD_PRG0] = v;
                CMD_MIRROR: mirror = v[1:0];
                CMD_IRQ_CTRL: begin
                  count_en   = v[7];
                  trigger_en = v[0];
                  // only switching the trigger off acknowledges a pending IRQ
                  if (!v[0]) irq_pending = 1'b0;
                end
                CMD_IRQ_LO: irq_count[7:0] = v;
                CMD_IRQ_HI: irq_count[15:8] = v;
                default: ;
              endcase
            end
          end
        end
        REQ_TICK: begin
          if (count_en) begin
            irq_count = irq_count - 16'd1;
            if (irq_count == '0) begin
              irq_count = IRQ_RELOAD;
              if (trigger_en) irq_pending = 1'b1;
            end
          end
        end
        REQ_PRG: begin
          if (win >= WIN_LOW) begin
            res.access_enabled = 1'b1;
            if (win == WIN_LOW && low_is_ram) begin
              // RAM bank bypasses the ROM mask
              bank               = {2'b00, low_bank};
              res.target_is_ram  = 1'b1;
              res.access_enabled = ram_enable;
            end else if (win == WIN_LOW) begin
              bank = {2'b00, low_bank} & prg_mask;
            end else if (win == WIN_FIXED) begin
              bank = prg_mask;
            end else begin
              bank = prg_bank[win - WIN_PRG_BASE] & prg_mask;
            end
            res.mapped_address = {bank, req.cpu_address[12:0]};
          end
        end
        REQ_CHR: begin
          if (win == WIN_CHR) begin
            res.mapped_address = {3'b000, chr_bank[req.cpu_address[12:10]],
                                  req.cpu_address[9:0]};
            res.target_is_ram  = !chr_rom;
            res.access_enabled = 1'b1;
          end
        end
        default: ;
      endcase
      res.mirroring_mode = mirror;
      res.irq_line       = irq_pending;
      expected_q.push_back(res);
    endfunction

    function void flag(string field, logic [20:0] want, logic [20:0] got);
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result 0x%0h arrived with nothing expected", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.mapped_address !== want.mapped_address)
          flag("mapped_address", want.mapped_address, got.mapped_address);
        if (got.target_is_ram !== want.target_is_ram)
          flag("target_is_ram", 21'(want.target_is_ram), 21'(got.target_is_ram));
        if (got.access_enabled !== want.access_enabled)
          flag("access_enabled", 21'(want.access_enabled), 21'(got.access_enabled));
        if (got.mirroring_mode !== want.mirroring_mode)
          flag("mirroring_mode", 21'(want.mirroring_mode), 21'(got.mirroring_mode));
        if (got.irq_line !== want.irq_line)
          flag("irq_line", 21'(want.irq_line), 21'(got.irq_line));
      end
    endfunction
  endclass

endpackage

[dv/cartridge_bank_mapper_with_irq_counter_test.sv]
module cartridge_bank_mapper_with_irq_counter_test;
  import cbm_pkg::*;
  import mapper_scoreboard_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned PHASES       = 6;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  mapper_scoreboard sb;

  cartridge_bank_mapper_with_irq_counter u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic in_t make_beat(logic [1:0] kind, logic [15:0] a, logic [7:0] d);
    in_t b;
    b.req_type    = kind;
    b.cpu_address = a;
    b.data_value  = d;
    return b;
  endfunction

  // Enter at a falling edge, leave at the falling edge after the beat is taken.
  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(beat);
    @(negedge clk);
  endtask

  task automatic send_write(logic [15:0] a, logic [7:0] d);
    send_beat(make_beat(REQ_WRITE, a, d));
  endtask

  task automatic program_config(logic [7:0] mask, logic rom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_MASK;
    cfg_data  <= mask;
    @(negedge clk);
    cfg_index <= CFG_CHR_ROM;
    cfg_data  <= {7'b0, rom};
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_config(mask, rom);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_directed();
    send_beat(make_beat(REQ_PRG, 16'h0000, 8'hFF));   // below the 0x6000 window
    send_beat(make_beat(REQ_CHR, 16'h2000, 8'h00));   // past the pattern tables
    send_write(16'h8000, 8'hF8);                      // high nibble of command ignored
    send_write(16'hA000, 8'hC5);                      // low window as enabled RAM
    send_beat(make_beat(REQ_PRG, 16'h6000, 8'h00));
    send_write(16'hBFFF, 8'h3F);                      // low window back to ROM
    send_beat(make_beat(REQ_PRG, 16'h7FFF, 8'h00));
    send_beat(make_beat(REQ_PRG, 16'hFFFF, 8'h00));   // fixed last bank
    send_beat(make_beat(REQ_CHR, 16'h1FFF, 8'hFF));
    send_write(16'hC000, 8'h0C);                      // sound port: drop
    send_write(16'h7FFF, 8'h0C);                      // below command range: drop
    send_write(16'h9FFF, {4'h0, CMD_IRQ_LO});
    send_write(16'hA000, 8'h02);
    send_write(16'h8000, {4'h0, CMD_IRQ_HI});
    send_write(16'hA000, 8'h00);
    send_write(16'h8000, {4'h0, CMD_IRQ_CTRL});
    send_write(16'hA000, 8'h81);
    send_beat(make_beat(REQ_TICK, 16'hFFFF, 8'hFF));
    send_beat(make_beat(REQ_TICK, 16'h0000, 8'h00));  // counter hits zero, IRQ rises
    send_write(16'hA000, 8'h80);                      // trigger off clears IRQ
    send_write(16'h8000, {4'h0, CMD_IRQ_HI});
    send_write(16'hA000, 8'h00);
    send_write(16'h8000, {4'h0, CMD_IRQ_LO});
    send_write(16'hA000, 8'h00);                      // counter now zero
    send_beat(make_beat(REQ_TICK, 16'h1234, 8'h5A));  // wraps without IRQ
  endtask

  task automatic random_episode(output int unsigned sent);
    int unsigned pick;
    int unsigned reps;
    logic [3:0]  cmd;
    logic [7:0]  v;
    logic [15:0] a;
    pick = $urandom_range(99);
    sent = 1;
    a    = 16'($urandom);
    if (pick < 30) begin
      cmd = 4'($urandom_range(15));
      v   = 8'($urandom);
      // keep the counter short so it actually expires
      if (cmd == CMD_IRQ_LO && $urandom_range(3) != 0) v = 8'($urandom_range(8));
      if (cmd == CMD_IRQ_HI && $urandom_range(3) != 0) v = 8'h00;
      if (cmd == CMD_IRQ_CTRL && $urandom_range(3) != 0) v[7] = 1'b1;
      send_write({RANGE_CMD, 13'($urandom)}, {4'($urandom), cmd});
      send_write({RANGE_PARAM, 13'($urandom)}, v);
      sent = 2;
    end else if (pick < 45) begin
      reps = $urandom_range(6, 1);
      repeat (reps) send_beat(make_beat(REQ_TICK, 16'($urandom), 8'($urandom)));
      sent = reps;
    end else if (pick < 65) begin
      if ($urandom_range(4) != 0) a[15:13] = 3'($urandom_range(WIN_FIXED, WIN_LOW));
      send_beat(make_beat(REQ_PRG, a, 8'($urandom)));
    end else if (pick < 85) begin
      if ($urandom_range(4) != 0) a[15:13] = WIN_CHR;
      send_beat(make_beat(REQ_CHR, a, 8'($urandom)));
    end else begin
      // stray write anywhere, or a parameter with no fresh command
      if ($urandom_range(1) != 0) a[15:13] = RANGE_PARAM;
      send_write(a, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned step;
    logic [7:0]  mask;
    logic        rom;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PRG_MASK;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      case (ph)
        0: begin mask = 8'hFF; rom = 1'b1; end
        1: begin mask = 8'h00; rom = 1'b0; end
        2: begin mask = 8'h3F; rom = 1'b1; end
        3: begin mask = 8'h80; rom = 1'b0; end
        4: begin mask = 8'($urandom); rom = 1'($urandom); end
        default: begin mask = 8'hFF; rom = 1'b0; end
      endcase
      program_config(mask, rom);
      if (ph == 0) run_directed();
      n = 0;
      while (n < RANDOM_ITEMS / PHASES) begin
        random_episode(step);
        n += step;
      end
      in_valid <= 1'b0;
      drain();
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
